@@ rtl/spt_pkg.sv @@
`default_nettype none
package spt_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned MagW      = 16;
  localparam int unsigned TotW      = 22;
  localparam int unsigned PressW    = 16;
  localparam int unsigned PhaseW    = 17;
  localparam int unsigned CoefW     = 33;
  localparam int unsigned ProdW     = PhaseW + CoefW;

  localparam logic [CoefW-1:0] S1 = 33'd6746518852;
  localparam logic [CoefW-1:0] S3 = 33'd2774394673;
  localparam logic [CoefW-1:0] S5 = 33'd342277223;
  localparam logic [CoefW-1:0] S7 = 33'd20107981;
  localparam logic [CoefW-1:0] S9 = 33'd689090;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [15:0]        pen_pressure;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  point_index;
    logic [15:0] new_pressure;
    logic        last_result;
    logic        points_dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQADD, ST_SQRT, ST_STORE,
    ST_READ, ST_EVAL, ST_PREP, ST_DIV, ST_MUL, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MOP_XX, MOP_YY, MOP_PP, MOP_QS9, MOP_QT, MOP_PT
  } mop_e;

  typedef enum logic [2:0] {
    PST_Q, PST_S7, PST_S5, PST_S3, PST_S1, PST_OUT
  } pst_e;

  typedef struct packed {
    logic in_load;
    logic mul_go;
    mop_e mul_op;
    logic sq_first;
    logic sq_add;
    logic sq_step;
    logic store;
    logic ovf_set;
    logic walk_start;
    logic rd;
    logic eval;
    logic press_zero;
    logic div_init;
    logic div_step;
    logic div_first;
    logic post;
    pst_e post_op;
    logic emit;
    logic stroke_clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic full;
    logic active;
    logic tot_zero;
    logic out_free;
    logic walk_end;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/spt_ctrl.sv @@
`default_nettype none
module spt_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  wire  spt_pkg::sts_t sts_i,
  output spt_pkg::cmd_t  cmd_o
);

  spt_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       acc;
  logic [2:0] k;

  assign in_stall_o = (state_q != spt_pkg::ST_IDLE);
  assign acc = in_valid_i & ~in_stall_o;
  assign k = cnt_q[3:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spt_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 5'd1;
    case (state_q)
      spt_pkg::ST_IDLE: begin
        if (acc) begin
          if (!sts_i.full) state_d = spt_pkg::ST_SQX;
          else if (sts_i.last) state_d = spt_pkg::ST_READ;
        end
      end
      spt_pkg::ST_SQX: state_d = spt_pkg::ST_SQY;
      spt_pkg::ST_SQY: state_d = spt_pkg::ST_SQADD;
      spt_pkg::ST_SQADD: begin
        state_d = spt_pkg::ST_SQRT;
        cnt_d   = '0;
      end
      spt_pkg::ST_SQRT: if (cnt_q == 5'd15) state_d = spt_pkg::ST_STORE;
      spt_pkg::ST_STORE: state_d = sts_i.last ? spt_pkg::ST_READ : spt_pkg::ST_IDLE;
      spt_pkg::ST_READ: state_d = spt_pkg::ST_EVAL;
      spt_pkg::ST_EVAL: begin
        state_d = (sts_i.active && !sts_i.tot_zero) ? spt_pkg::ST_PREP : spt_pkg::ST_EMIT;
      end
      spt_pkg::ST_PREP: begin
        state_d = spt_pkg::ST_DIV;
        cnt_d   = '0;
      end
      spt_pkg::ST_DIV: begin
        if (cnt_q == 5'd16) begin
          state_d = spt_pkg::ST_MUL;
          cnt_d   = '0;
        end
      end
      spt_pkg::ST_MUL: if (cnt_q == 5'd11) state_d = spt_pkg::ST_EMIT;
      spt_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.walk_end ? spt_pkg::ST_IDLE : spt_pkg::ST_READ;
        end
      end
      default: state_d = spt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_op  = spt_pkg::MOP_XX;
    cmd_o.post_op = spt_pkg::PST_Q;
    case (state_q)
      spt_pkg::ST_IDLE: begin
        if (acc) begin
          cmd_o.in_load    = ~sts_i.full;
          cmd_o.ovf_set    = sts_i.full;
          cmd_o.walk_start = sts_i.full;
        end
      end
      spt_pkg::ST_SQX: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = spt_pkg::MOP_XX;
      end
      spt_pkg::ST_SQY: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_op   = spt_pkg::MOP_YY;
        cmd_o.sq_first = 1'b1;
      end
      spt_pkg::ST_SQADD: cmd_o.sq_add = 1'b1;
      spt_pkg::ST_SQRT: cmd_o.sq_step = 1'b1;
      spt_pkg::ST_STORE: begin
        cmd_o.store      = 1'b1;
        cmd_o.walk_start = sts_i.last;
      end
      spt_pkg::ST_READ: cmd_o.rd = 1'b1;
      spt_pkg::ST_EVAL: begin
        cmd_o.eval       = 1'b1;
        cmd_o.press_zero = ~(sts_i.active & ~sts_i.tot_zero);
      end
      spt_pkg::ST_PREP: cmd_o.div_init = 1'b1;
      spt_pkg::ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == 5'd0);
      end
      spt_pkg::ST_MUL: begin
        cmd_o.mul_go = ~cnt_q[0];
        cmd_o.post   = cnt_q[0];
        case (k)
          3'd0: begin
            cmd_o.mul_op  = spt_pkg::MOP_PP;
            cmd_o.post_op = spt_pkg::PST_Q;
          end
          3'd1: begin
            cmd_o.mul_op  = spt_pkg::MOP_QS9;
            cmd_o.post_op = spt_pkg::PST_S7;
          end
          3'd2: begin
            cmd_o.mul_op  = spt_pkg::MOP_QT;
            cmd_o.post_op = spt_pkg::PST_S5;
          end
          3'd3: begin
            cmd_o.mul_op  = spt_pkg::MOP_QT;
            cmd_o.post_op = spt_pkg::PST_S3;
          end
          3'd4: begin
            cmd_o.mul_op  = spt_pkg::MOP_QT;
            cmd_o.post_op = spt_pkg::PST_S1;
          end
          default: begin
            cmd_o.mul_op  = spt_pkg::MOP_PT;
            cmd_o.post_op = spt_pkg::PST_OUT;
          end
        endcase
      end
      spt_pkg::ST_EMIT: begin
        cmd_o.emit         = sts_i.out_free;
        cmd_o.stroke_clear = sts_i.out_free & sts_i.walk_end;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/spt_dp.sv @@
`default_nettype none
module spt_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  spt_pkg::in_item_t in_data_i,
  input  wire  spt_pkg::cmd_t  cmd_i,
  output spt_pkg::sts_t        sts_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output spt_pkg::out_item_t   out_data_o
);

  localparam int unsigned IdxW  = spt_pkg::IdxW;
  localparam int unsigned CntW  = spt_pkg::CntW;
  localparam int unsigned MagW  = spt_pkg::MagW;
  localparam int unsigned TotW  = spt_pkg::TotW;
  localparam int unsigned PW    = spt_pkg::PhaseW;
  localparam int unsigned CW    = spt_pkg::CoefW;
  localparam int unsigned ProdW = spt_pkg::ProdW;

  logic [MagW-1:0] mag_mem [spt_pkg::MaxPoints];
  logic            act_mem [spt_pkg::MaxPoints];

  logic [15:0]     ax_q, ay_q;
  logic            act_q, last_q;
  logic [31:0]     v_q, res_q, bit_q;
  logic [TotW-1:0] total_q, len_q;
  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic [IdxW-1:0] idx_q;
  logic [MagW-1:0] rd_mag_q;
  logic            rd_act_q;
  logic [TotW:0]   r_q;
  logic [PW-1:0]   p_q, q_q;
  logic [CW-1:0]   t_q;
  logic [ProdW-1:0] prod_q;
  logic [15:0]     press_q;
  logic            out_valid_q;
  spt_pkg::out_item_t out_q;

  logic [PW-1:0]   mul_a;
  logic [CW-1:0]   mul_b;
  logic [31:0]     sum_rb;
  logic [TotW:0]   twice, dev, r_sh, r_sub;
  logic [TotW-1:0] num;
  logic [CW:0]     horner;
  logic [ProdW:0]  rnd;
  logic [PW+1:0]   s_full;
  logic            out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      spt_pkg::MOP_XX: begin
        mul_a = {1'b0, ax_q};
        mul_b = {{(CW-16){1'b0}}, ax_q};
      end
      spt_pkg::MOP_YY: begin
        mul_a = {1'b0, ay_q};
        mul_b = {{(CW-16){1'b0}}, ay_q};
      end
      spt_pkg::MOP_PP: begin
        mul_a = p_q;
        mul_b = {{(CW-PW){1'b0}}, p_q};
      end
      spt_pkg::MOP_QS9: begin
        mul_a = q_q;
        mul_b = spt_pkg::S9;
      end
      spt_pkg::MOP_QT: begin
        mul_a = q_q;
        mul_b = t_q;
      end
      spt_pkg::MOP_PT: begin
        mul_a = p_q;
        mul_b = t_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    horner = '0;
    case (cmd_i.post_op)
      spt_pkg::PST_S7: horner = {1'b0, spt_pkg::S7} - {1'b0, prod_q[16 +: CW]};
      spt_pkg::PST_S5: horner = {1'b0, spt_pkg::S5} - {1'b0, prod_q[16 +: CW]};
      spt_pkg::PST_S3: horner = {1'b0, spt_pkg::S3} - {1'b0, prod_q[16 +: CW]};
      spt_pkg::PST_S1: horner = {1'b0, spt_pkg::S1} - {1'b0, prod_q[16 +: CW]};
      default: horner = '0;
    endcase
  end

  assign rnd    = {1'b0, prod_q} + ((ProdW+1)'(1) << 31);
  assign s_full = rnd[32 +: PW+2];

  assign sum_rb = res_q + bit_q;

  assign twice = {len_q, 1'b0};
  assign dev   = (twice > {1'b0, total_q}) ? twice - {1'b0, total_q}
                                           : {1'b0, total_q} - twice;
  assign num   = (dev > {1'b0, total_q}) ? '0 : total_q - dev[TotW-1:0];
  assign r_sh  = cmd_i.div_first ? r_q : {r_q[TotW-1:0], 1'b0};
  assign r_sub = r_sh - {1'b0, total_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      ax_q   <= in_data_i.x_coord[15] ? 16'(-in_data_i.x_coord) : in_data_i.x_coord;
      ay_q   <= in_data_i.y_coord[15] ? 16'(-in_data_i.y_coord) : in_data_i.y_coord;
      act_q  <= (in_data_i.pen_pressure != 16'd0);
    end
    if (cmd_i.mul_go) prod_q <= {{(ProdW-PW){1'b0}}, mul_a} * {{(ProdW-CW){1'b0}}, mul_b};
    if (cmd_i.sq_first) v_q <= prod_q[31:0];
    if (cmd_i.sq_add) begin
      v_q   <= v_q + prod_q[31:0];
      res_q <= '0;
      bit_q <= 32'h4000_0000;
    end
    if (cmd_i.sq_step) begin
      if (v_q >= sum_rb) begin
        v_q   <= v_q - sum_rb;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.store) begin
      mag_mem[count_q[IdxW-1:0]] <= res_q[MagW-1:0];
      act_mem[count_q[IdxW-1:0]] <= act_q;
    end
    if (cmd_i.rd) begin
      rd_mag_q <= mag_mem[idx_q];
      rd_act_q <= act_mem[idx_q];
    end
    if (cmd_i.walk_start) len_q <= '0;
    else if (cmd_i.eval && rd_act_q) len_q <= len_q + TotW'(rd_mag_q);
    if (cmd_i.div_init) begin
      r_q <= {1'b0, num};
      p_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (r_sh >= {1'b0, total_q}) begin
        r_q <= r_sub;
        p_q <= {p_q[PW-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        p_q <= {p_q[PW-2:0], 1'b0};
      end
    end
    if (cmd_i.post) begin
      if (cmd_i.post_op == spt_pkg::PST_Q) q_q <= prod_q[16 +: PW];
      else if (cmd_i.post_op == spt_pkg::PST_OUT)
        press_q <= (s_full > (PW+2)'(16'hFFFF)) ? 16'hFFFF : s_full[15:0];
      else t_q <= horner[CW-1:0];
    end
    if (cmd_i.press_zero) press_q <= '0;
    if (cmd_i.emit) begin
      out_q.point_index    <= idx_q;
      out_q.new_pressure   <= press_q;
      out_q.last_result    <= ({1'b0, idx_q} + CntW'(1)) == count_q;
      out_q.points_dropped <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.in_load || cmd_i.ovf_set) last_q <= in_data_i.last_point;
      if (cmd_i.ovf_set) ovf_q <= 1'b1;
      if (cmd_i.store) begin
        count_q <= count_q + CntW'(1);
        if (act_q) total_q <= total_q + TotW'(res_q[MagW-1:0]);
      end
      if (cmd_i.walk_start) idx_q <= '0;
      else if (cmd_i.emit) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.stroke_clear) begin
        total_q <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.last     = cmd_i.ovf_set ? in_data_i.last_point : last_q;
  assign sts_o.full     = (count_q == CntW'(spt_pkg::MaxPoints));
  assign sts_o.active   = rd_act_q;
  assign sts_o.tot_zero = (total_q == '0);
  assign sts_o.out_free = out_free;
  assign sts_o.walk_end = ({1'b0, idx_q} + CntW'(1)) == count_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/stroke_pressure_taper.sv @@
// Stroke pressure taper.
// Input channel: one point per transfer (x, y, pressure, last flag) on
// in_valid_i / in_stall_o. Output channel: one result per stored point on
// out_valid_o / out_stall_i.
// A point is accepted only while the block is idle. A stored point holds
// the input stall until it is stored, so the next point waits for it: a
// shared 17x33 multiplier forms x*x and y*y, the two squares are summed,
// then a 16-step square root runs and the point is stored.
// A point that arrives with the store full is dropped.
// After the last point the stored points are walked in order. An active
// point with nonzero total takes a memory read, a 17-step divider for
// the phase and six multiplies of the sine polynomial on the shared
// multiplier. Any other point is read and emitted with zero pressure.
// Results pass through one output register; the next result is computed
// while it waits, and the walk holds while the receiver stalls.
// Reset clears the point count, running total, overflow flag and the
// output valid; the point store itself is not cleared.
`default_nettype none
module stroke_pressure_taper (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  spt_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output spt_pkg::out_item_t     out_data_o
);

  spt_pkg::cmd_t cmd;
  spt_pkg::sts_t sts;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam logic [32:0] C1 = 33'd6746518852;
  localparam logic [32:0] C3 = 33'd2774394673;
  localparam logic [32:0] C5 = 33'd342277223;
  localparam logic [32:0] C7 = 33'd20107981;
  localparam logic [32:0] C9 = 33'd689090;
  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  spt_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  spt_pkg::out_item_t out_data_o;

  stroke_pressure_taper u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #2 clk_i = ~clk_i;

  logic [15:0] mag_mem [spt_pkg::MaxPoints];
  logic        act_mem [spt_pkg::MaxPoints];
  logic [21:0] tot_len = '0;
  int unsigned pt_cnt = 0;
  logic        ovf = 1'b0;
  spt_pkg::out_item_t pending_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          hold_off = 1'b0;
  int unsigned gap_max = 3;

  function automatic logic [15:0] int_sqrt(logic [31:0] v);
    logic [31:0] r;
    logic [31:0] b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[15:0];
  endfunction

  function automatic logic [15:0] taper_press(logic [31:0] len, logic [31:0] tot);
    logic [63:0] tw, dev, num, p, q, t, s;
    tw = 2 * len;
    dev = (tw > tot) ? tw - tot : tot - tw;
    num = (dev > tot) ? 0 : tot - dev;
    p = (num << 16) / tot;
    if (p > 65536) p = 65536;
    q = (p * p) >> 16;
    t = C7 - ((q * C9) >> 16);
    t = C5 - ((q * t) >> 16);
    t = C3 - ((q * t) >> 16);
    t = C1 - ((q * t) >> 16);
    s = (p * t + (64'd1 << 31)) >> 32;
    if (s > 65535) s = 65535;
    return s[15:0];
  endfunction

  task automatic predict_point(spt_pkg::in_item_t it);
    int ax, ay;
    logic [15:0] m;
    logic [31:0] len;
    spt_pkg::out_item_t r;
    if (pt_cnt < spt_pkg::MaxPoints) begin
      ax = (it.x_coord < 0) ? -int'(it.x_coord) : int'(it.x_coord);
      ay = (it.y_coord < 0) ? -int'(it.y_coord) : int'(it.y_coord);
      m = int_sqrt(ax * ax + ay * ay);
      mag_mem[pt_cnt] = m;
      act_mem[pt_cnt] = (it.pen_pressure != 0);
      if (it.pen_pressure != 0) tot_len = tot_len + m;
      pt_cnt++;
    end else begin
      ovf = 1'b1;
    end
    if (!it.last_point) return;
    len = 0;
    for (int k = 0; k < pt_cnt; k++) begin
      r.point_index = k[5:0];
      r.new_pressure = '0;
      if (act_mem[k]) begin
        len = len + mag_mem[k];
        if (tot_len != 0) r.new_pressure = taper_press(len, {10'd0, tot_len});
      end
      r.last_result = (k + 1 == pt_cnt);
      r.points_dropped = ovf;
      pending_results.push_back(r);
    end
    tot_len = '0;
    pt_cnt = 0;
    ovf = 1'b0;
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic [15:0] pr, logic lst);
    spt_pkg::in_item_t it;
    it = '{x_coord: x, y_coord: y, pen_pressure: pr, last_point: lst};
    if (gap_max != 0 && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_point(it);
  endtask

  task automatic send_stroke(int n, int zero_pct, int small_coords);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = small_coords ? 16'($signed($urandom_range(0, 400)) - 200) : 16'($urandom);
      y = small_coords ? 16'($signed($urandom_range(0, 400)) - 200) : 16'($urandom);
      send_point(x, y, ($urandom_range(0, 99) < zero_pct) ? 16'd0 : 16'($urandom | 1),
                 i == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 9) < 3) && (cycles % 256 > 64);
  end

  always @(posedge clk_i) begin
    spt_pkg::out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data_o !== e) begin
          $display("%0t mismatch expected %p actual %p", $time, e, out_data_o);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_point(16'sh7fff, 16'sh7fff, 16'hffff, 1'b0);
    send_point(-16'sh8000, -16'sh8000, 16'h0001, 1'b0);
    send_point(16'sh0000, 16'sh0000, 16'h8000, 1'b0);
    send_point(16'sh7fff, -16'sh8000, 16'h0000, 1'b0);
    send_point(16'sh0010, 16'sh0020, 16'h5555, 1'b1);
    send_point(16'sh0040, 16'sh0000, 16'haaaa, 1'b1);
    wait_drained();
  endtask

  task automatic test_zero_total();
    send_point(16'sh0000, 16'sh0000, 16'h1234, 1'b0);
    send_point(16'sh0100, 16'sh0100, 16'h0000, 1'b0);
    send_point(16'sh0000, 16'sh0000, 16'hffff, 1'b1);
    send_point(16'sh0100, 16'sh0100, 16'h0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow();
    send_stroke(spt_pkg::MaxPoints + 3, 10, 1);
    send_stroke(spt_pkg::MaxPoints, 0, 1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (800) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    send_stroke(4, 20, 1);
    send_stroke(3, 0, 1);
    send_stroke(2, 0, 1);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 300) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 8);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      send_stroke(n, $urandom_range(0, 50), $urandom_range(0, 1));
      sent += n;
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_zero_total();
    test_overflow();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
